// File: design/half_selection_sort_merge_macros.svh
// Assertion macros for the half selection sort merge block.
// Included by the controller; depends on nothing else.
`ifndef HALF_SELECTION_SORT_MERGE_MACROS_SVH
`define HALF_SELECTION_SORT_MERGE_MACROS_SVH

// Check holds in the same cycle as the condition.
`define HSSM_ASSERT_HOLDS(label, clock, reset, cond, check, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (check)) \
    else $error(msg);

// Check holds in the cycle after the condition.
`define HSSM_ASSERT_NEXT(label, clock, reset, cond, check, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (check)) \
    else $error(msg);

`endif

// File: design/hssm_pkg.sv
// Shared types and constants for the half selection sort merge block.
// No dependencies; compiled first.
package hssm_pkg;

  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    WSEL_SAMPLE,
    WSEL_CUR,
    WSEL_BEST
  } wsel_t;

  typedef struct packed {
    logic  we;
    wsel_t wsel;
    logic  load_init;
    logic  load_best;
    logic  load_out;
    logic  out_sel_a;
    logic  out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic less;
    logic a_le_b;
    logic out_busy;
  } dp_stat_t;

endpackage

// File: design/hssm_stream_if.sv
// Valid/ready stream interfaces for sample beats and result beats.
// Depends on hssm_pkg for the data width.
interface hssm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [hssm_pkg::DATA_W-1:0]  sample_value;
  logic                                final_item;

  modport source (output valid, output sample_value, output final_item, input ready);
  modport sink   (input valid, input sample_value, input final_item, output ready);
endinterface

interface hssm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [hssm_pkg::DATA_W-1:0]  sorted_value;
  logic                                run_end;

  modport source (output valid, output sorted_value, output run_end, input ready);
  modport sink   (input valid, input sorted_value, input run_end, output ready);
endinterface

// File: design/hssm_datapath.sv
// Datapath: value memory with two registered read ports, scan registers, output register.
// Depends on hssm_pkg; driven by hssm_ctrl.
module hssm_datapath #(
  parameter int MAX_ITEMS = 64,
  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic signed [hssm_pkg::DATA_W-1:0] sample_value,
  input  hssm_pkg::dp_cmd_t                  cmd,
  input  logic [AW-1:0]                      waddr,
  input  logic [AW-1:0]                      raddr0,
  input  logic [AW-1:0]                      raddr1,
  output hssm_pkg::dp_stat_t                 stat,
  output logic signed [hssm_pkg::DATA_W-1:0] sorted_value,
  output logic                               run_end,
  output logic                               out_valid,
  input  logic                               out_ready
);
  import hssm_pkg::*;

  logic signed [DATA_W-1:0] mem [MAX_ITEMS];
  logic signed [DATA_W-1:0] rd0;
  logic signed [DATA_W-1:0] rd1;
  logic signed [DATA_W-1:0] cur;
  logic signed [DATA_W-1:0] best;
  logic signed [DATA_W-1:0] wdata;

  always_comb begin
    unique case (cmd.wsel)
      WSEL_SAMPLE: wdata = sample_value;
      WSEL_CUR:    wdata = cur;
      WSEL_BEST:   wdata = best;
      default:     wdata = sample_value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[waddr] <= wdata;
    end
    rd0 <= mem[raddr0];
    rd1 <= mem[raddr1];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_init) begin
      cur  <= rd0;
      best <= rd0;
    end else if (cmd.load_best) begin
      best <= rd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      sorted_value <= cmd.out_sel_a ? rd0 : rd1;
      run_end      <= cmd.out_last;
    end
  end

  assign stat.less     = rd0 < best;
  assign stat.a_le_b   = rd0 <= rd1;
  assign stat.out_busy = out_valid;

endmodule

// File: design/hssm_ctrl.sv
// Controller: load, selection sort of each half, two-way merge sequencing.
// Depends on hssm_pkg and the assertion macro header; drives hssm_datapath.
`include "half_selection_sort_merge_macros.svh"

module hssm_ctrl #(
  parameter int MAX_ITEMS = 64,
  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
  localparam int CW = $clog2(MAX_ITEMS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               final_item,
  output logic               in_ready,
  output hssm_pkg::dp_cmd_t  cmd,
  input  hssm_pkg::dp_stat_t stat,
  output logic [AW-1:0]      waddr,
  output logic [AW-1:0]      raddr0,
  output logic [AW-1:0]      raddr1
);
  import hssm_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD,
    S_SEL_START,
    S_SEL_INIT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SWAP_POS,
    S_SWAP_LOW,
    S_MRG_RD,
    S_MRG_SEL
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [CW-1:0] n_total;
  logic [CW-1:0] mid;
  logic [CW-1:0] hi;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic [AW-1:0] pos;
  logic          upper;
  logic [CW-1:0] a;
  logic [CW-1:0] b;
  logic [CW-1:0] k;

  logic          room;
  logic [CW-1:0] n_after;
  logic          take_a;

  assign room     = count < CW'(MAX_ITEMS);
  assign n_after  = count + CW'(room);
  assign take_a   = (a < mid) && ((b >= n_total) || stat.a_le_b);
  assign in_ready = state == S_LOAD;
  assign raddr1   = b[AW-1:0];

  always_comb begin
    cmd           = '0;
    cmd.wsel      = WSEL_SAMPLE;
    cmd.out_sel_a = take_a;
    cmd.out_last  = (k + CW'(1)) == n_total;
    waddr         = count[AW-1:0];
    raddr0        = i[AW-1:0];
    unique case (state)
      S_LOAD: begin
        cmd.we = in_valid && room;
      end
      S_SEL_INIT: begin
        cmd.load_init = 1'b1;
      end
      S_SCAN_RD: begin
        raddr0 = j[AW-1:0];
      end
      S_SCAN_CMP: begin
        cmd.load_best = stat.less;
      end
      S_SWAP_POS: begin
        cmd.we   = 1'b1;
        cmd.wsel = WSEL_CUR;
        waddr    = pos;
      end
      S_SWAP_LOW: begin
        cmd.we   = 1'b1;
        cmd.wsel = WSEL_BEST;
        waddr    = i[AW-1:0];
      end
      S_MRG_RD: begin
        raddr0 = a[AW-1:0];
      end
      S_MRG_SEL: begin
        raddr0       = a[AW-1:0];
        cmd.load_out = !stat.out_busy;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (room) begin
              count <= count + CW'(1);
            end
            if (final_item) begin
              n_total <= n_after;
              mid     <= n_after >> 1;
              hi      <= n_after >> 1;
              i       <= '0;
              upper   <= 1'b0;
              state   <= S_SEL_START;
            end
          end
        end
        S_SEL_START: begin
          if (i >= hi) begin
            if (!upper) begin
              upper <= 1'b1;
              i     <= mid;
              hi    <= n_total;
            end else begin
              a     <= '0;
              b     <= mid;
              k     <= '0;
              state <= S_MRG_RD;
            end
          end else begin
            j     <= i + CW'(1);
            pos   <= i[AW-1:0];
            state <= S_SEL_INIT;
          end
        end
        S_SEL_INIT: begin
          state <= S_SCAN_RD;
        end
        S_SCAN_RD: begin
          state <= (j >= hi) ? S_SWAP_POS : S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          if (stat.less) begin
            pos <= j[AW-1:0];
          end
          j     <= j + CW'(1);
          state <= S_SCAN_RD;
        end
        S_SWAP_POS: begin
          state <= S_SWAP_LOW;
        end
        S_SWAP_LOW: begin
          i     <= i + CW'(1);
          state <= S_SEL_START;
        end
        S_MRG_RD: begin
          if (k == n_total) begin
            count <= '0;
            state <= S_LOAD;
          end else begin
            state <= S_MRG_SEL;
          end
        end
        S_MRG_SEL: begin
          if (!stat.out_busy) begin
            if (take_a) begin
              a <= a + CW'(1);
            end else begin
              b <= b + CW'(1);
            end
            k     <= k + CW'(1);
            state <= S_MRG_RD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  `HSSM_ASSERT_HOLDS(a_count_bound, clk, rst, 1'b1, count <= CW'(MAX_ITEMS), "count overflow")
  `HSSM_ASSERT_HOLDS(a_scan_range, clk, rst, state == S_SCAN_CMP, (j < hi) && (CW'(pos) < j), "scan out of range")
  `HSSM_ASSERT_HOLDS(a_merge_heads, clk, rst, state == S_MRG_SEL, (a <= mid) && (b <= n_total) && (k < n_total), "merge heads out of range")
  `HSSM_ASSERT_NEXT(a_last_beat, clk, rst, cmd.load_out && cmd.out_last, (state == S_MRG_RD) && (k == n_total), "last beat before merge end")

endmodule

// File: design/half_selection_sort_merge.sv
// Channel   | Dir | Payload                     | Handshake
// samples   | in  | sample_value, final_item    | valid/ready
// results   | out | sorted_value, run_end       | valid/ready
// A sample beat is taken when valid and ready meet; samples is not ready while a set sorts and merges.
// Sort: each position runs start and init, a read and a compare per candidate, then the swaps,
// on the single scan read port; about n*n/4 compares per set. Merge reads, then selects a result.
// Reset clears control state only; the value memory holds no reset value.
// A stalled results beat holds the merge; new samples are taken while the last beat waits.
module half_selection_sort_merge #(
  parameter int MAX_ITEMS = 64
) (
  input logic       clk,
  input logic       rst,
  hssm_in_if.sink   samples,
  hssm_out_if.source results
);
  import hssm_pkg::*;

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr0;
  logic [AW-1:0] raddr1;
  logic          in_ready;
  logic          out_valid;

  hssm_ctrl #(.MAX_ITEMS(MAX_ITEMS)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (samples.valid),
    .final_item (samples.final_item),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .stat       (stat),
    .waddr      (waddr),
    .raddr0     (raddr0),
    .raddr1     (raddr1)
  );

  hssm_datapath #(.MAX_ITEMS(MAX_ITEMS)) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .sample_value (samples.sample_value),
    .cmd          (cmd),
    .waddr        (waddr),
    .raddr0       (raddr0),
    .raddr1       (raddr1),
    .stat         (stat),
    .sorted_value (results.sorted_value),
    .run_end      (results.run_end),
    .out_valid    (out_valid),
    .out_ready    (results.ready)
  );

  assign samples.ready = in_ready;
  assign results.valid = out_valid;

endmodule

// File: tb/tb_half_selection_sort_merge.sv
// Self-checking testbench for half_selection_sort_merge: sends sets of signed samples and
// checks every sorted result beat against an in-bench sort of the same set.
// Depends on hssm_pkg, the hssm_in_if/hssm_out_if interfaces and the block itself.
`timescale 1ns / 1ps

module tb_half_selection_sort_merge;
  import hssm_pkg::*;

  localparam int MAX_ITEMS   = 64;
  localparam int ITEM_GOAL   = 400;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = 20;

  typedef logic signed [DATA_W-1:0] word_t;

  localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef struct {
    word_t value;
    logic  last;
    logic  drain;
  } sample_t;

  typedef struct {
    word_t value;
    logic  last;
  } sorted_t;

  logic clk;
  logic rst;

  hssm_in_if  samples();
  hssm_out_if results();

  half_selection_sort_merge #(
    .MAX_ITEMS(MAX_ITEMS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .samples(samples),
    .results(results)
  );

  sample_t pending_q[$];
  sorted_t sorted_q[$];
  word_t   held[MAX_ITEMS];
  int      held_count;
  int      errors;
  int      quiet_cycles;
  int      burst_left;
  int      gap_left;
  int      items_queued;
  bit      in_taken;
  logic [15:0] stall_pat;
  logic [3:0]  stall_phase;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%t mismatch: %s", $realtime, msg);
  endtask

  task automatic sort_range(input int lo, input int hi);
    int    i;
    int    j;
    int    pos;
    word_t best;
    for (i = lo; i < hi; i++) begin
      pos  = i;
      best = held[i];
      for (j = i + 1; j < hi; j++) begin
        if (held[j] < best) begin
          pos  = j;
          best = held[j];
        end
      end
      held[pos] = held[i];
      held[i]   = best;
    end
  endtask

  task automatic take_sample(input sample_t s);
    int      mid;
    int      a;
    int      b;
    int      k;
    sorted_t r;
    if (held_count < MAX_ITEMS) begin
      held[held_count] = s.value;
      held_count++;
    end
    if (s.last) begin
      mid = held_count / 2;
      sort_range(0, mid);
      sort_range(mid, held_count);
      a = 0;
      b = mid;
      for (k = 0; k < held_count; k++) begin
        if (a < mid && (b >= held_count || held[a] <= held[b])) begin
          r.value = held[a];
          a++;
        end else begin
          r.value = held[b];
          b++;
        end
        r.last = (k == held_count - 1);
        sorted_q.push_back(r);
      end
      held_count = 0;
    end
  endtask

  task automatic queue_sample(input word_t value, input logic last, input logic drain);
    sample_t s;
    s.value = value;
    s.last  = last;
    s.drain = drain;
    pending_q.push_back(s);
    items_queued++;
  endtask

  task automatic queue_list(input word_t vals[$]);
    int i;
    for (i = 0; i < vals.size(); i++) queue_sample(vals[i], i == vals.size() - 1, 1'b0);
  endtask

  function automatic word_t pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return WORD_MIN;
          1: return WORD_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2, 3: return word_t'($urandom_range(0, 6)) - 3;
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic queue_random_set(input int size, input logic drain);
    int i;
    for (i = 0; i < size; i++) queue_sample(pick_value(), i == size - 1, drain && i == 0);
  endtask

  // Sample driver: predict on each accepted beat, present the next one on the falling edge.
  always @(posedge clk) begin
    in_taken = !rst && samples.valid && samples.ready;
    if (in_taken) take_sample(pending_q.pop_front());
  end

  always @(negedge clk) begin
    logic drive;
    drive = 1'b0;
    if (rst) begin
      drive = 1'b0;
    end else if (samples.valid && !in_taken) begin
      drive = 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
    end else if (pending_q.size() > 0 && (!pending_q[0].drain || sorted_q.size() == 0)) begin
      drive = 1'b1;
      samples.sample_value <= pending_q[0].value;
      samples.final_item   <= pending_q[0].last;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 30);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      end
    end
    samples.valid <= drive;
  end

  // Result monitor: compare each accepted beat with the oldest expected one.
  always @(posedge clk) begin
    sorted_t want;
    if (!rst && results.valid && results.ready) begin
      if (sorted_q.size() == 0) begin
        flag_error($sformatf("unexpected beat value=%0d run_end=%0b",
                             results.sorted_value, results.run_end));
      end else begin
        want = sorted_q.pop_front();
        if (results.sorted_value !== want.value || results.run_end !== want.last)
          flag_error($sformatf("expected value=%0d run_end=%0b, got value=%0d run_end=%0b",
                               want.value, want.last, results.sorted_value, results.run_end));
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
      stall_pat     = '1;
      stall_phase   = '0;
    end else begin
      if (stall_phase == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pat = '1;
          1: stall_pat = 16'($urandom);
          2: stall_pat = 16'($urandom | $urandom);
          default: stall_pat = 16'($urandom & $urandom);
        endcase
      end
      results.ready <= stall_pat[stall_phase];
      stall_phase = stall_phase + 4'd1;
    end
  end

  always @(posedge clk) begin
    if (rst || (samples.valid && samples.ready) || (results.valid && results.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int    set_no;
    int    size;
    word_t dir[$];
    clk                  = 1'b0;
    rst                  = 1'b1;
    samples.valid        = 1'b0;
    samples.sample_value = '0;
    samples.final_item   = 1'b0;
    results.ready        = 1'b0;
    held_count           = 0;
    errors               = 0;
    quiet_cycles         = 0;
    burst_left           = 8;
    gap_left             = 0;
    items_queued         = 0;
    in_taken             = 1'b0;
    stall_pat            = '1;
    stall_phase          = '0;

    dir = '{WORD_MIN};
    queue_list(dir);
    dir = '{WORD_MAX, WORD_MIN};
    queue_list(dir);
    dir = '{word_t'(0), word_t'(-1), WORD_MAX, WORD_MIN, word_t'(5)};
    queue_list(dir);
    dir = '{word_t'(7), word_t'(-2), word_t'(7), word_t'(-2), word_t'(7)};
    queue_list(dir);
    dir = '{word_t'(4), word_t'(3), word_t'(2), word_t'(1), word_t'(0), word_t'(-1),
            word_t'(-2)};
    queue_list(dir);

    set_no = 0;
    while (items_queued < ITEM_GOAL) begin
      case (set_no)
        4: size = MAX_ITEMS;
        5: size = MAX_ITEMS + 1;
        6: size = MAX_ITEMS + 3;
        default: size = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70)
                                                   : $urandom_range(1, 12);
      endcase
      queue_random_set(size, set_no == 2 || $urandom_range(0, 7) == 0);
      set_no++;
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || sorted_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (sorted_q.size() != 0) begin
      errors += sorted_q.size();
      $display("%0d expected beats never arrived", sorted_q.size());
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/hssm_pkg.sv
design/hssm_stream_if.sv
design/hssm_datapath.sv
design/hssm_ctrl.sv
design/half_selection_sort_merge.sv
tb/tb_half_selection_sort_merge.sv
